// ===== src/tcw_pkg.sv =====
// shared constants and helpers for the text console writer
`default_nettype none

package tcw_pkg;

  // default screen geometry
  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  // character and attribute codes
  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] ATTR_RESET = 8'h02;

  // command codes carried in tuser
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // cell layout: attribute in the upper byte, character in the lower byte
  localparam int CELL_W = 16;

  typedef logic [CELL_W-1:0] cell_t;

  function automatic cell_t make_cell(input logic [7:0] ch, input logic [7:0] attr);
    return {attr, ch};
  endfunction

endpackage

`default_nettype wire

// ===== src/tcw_ram.sv =====
// generic single-write, single-read synchronous ram with registered read data
`default_nettype none

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== src/text_console_writer_top.sv =====
// top level of the text console writer: cursor control, scroll ring and cell store
//
//  channel | direction | handshake                  | contents
//  --------+-----------+----------------------------+----------------------------------------
//  in_     | in        | in_tvalid / in_tready      | tuser: command; tdata: char, row, col
//  out_    | out       | out_tvalid / out_tready    | tdata: cell char, cell attr, cursor
//  cfg_    | in        | cfg_wr_en (no back-pressure)| text attribute
//
// one transaction in flight at a time; character writes, newlines, reads and unused
// commands pass from idle straight to the response state, while a write that scrolls
// blanks the new bottom row and a clear blanks every row in the fill state, one cell
// blanked per cycle, set by the single write port of the cell store
// after reset the store is blanked cell by cell with in_tready low
// the output register lets the next transaction in while a result waits on out_tready
// scrolling moves a top-row pointer and blanks the old top row; the rows form a ring in the store
`default_nettype none

module text_console_writer_top
  import tcw_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input transaction
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // [7:0] char_code, [12:8] read_row, [19:13] read_col
  input  wire logic [1:0]  in_tuser,   // [1:0] command
  // result transaction
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [31:0] out_tdata,  // [7:0] cell_char, [15:8] cell_attr,
                                       // [22:16] cursor_col, [27:23] cursor_row
  // configuration
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data // [7:0] text_attribute
);

  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);
  localparam int AW    = RW + CW;
  localparam int DEPTH = ROWS * (1 << CW);

  // sequencer states
  localparam logic [1:0] ST_INIT = 2'd0;  // power-on blanking sweep
  localparam logic [1:0] ST_IDLE = 2'd1;  // waiting for a transaction
  localparam logic [1:0] ST_FILL = 2'd2;  // blanking for clear or scroll
  localparam logic [1:0] ST_RESP = 2'd3;  // handing the result to the output register

  // row index in the store for a logical row, given the ring's top row
  function automatic logic [RW-1:0] ring_row(input logic [RW-1:0] top, input logic [RW-1:0] row);
    logic [RW:0] sum;
    sum = {1'b0, top} + {1'b0, row};
    if (sum >= (RW+1)'(ROWS)) begin
      sum = sum - (RW+1)'(ROWS);
    end
    return sum[RW-1:0];
  endfunction

  // registers
  logic [1:0]    state_r,     state_nxt;
  logic [CW-1:0] cur_col_r,   cur_col_nxt;
  logic [RW-1:0] cur_row_r,   cur_row_nxt;
  logic [RW-1:0] top_r,       top_nxt;
  logic [7:0]    attr_r,      attr_nxt;
  logic [CW-1:0] fill_col_r,  fill_col_nxt;
  logic [RW-1:0] fill_row_r,  fill_row_nxt;
  logic [RW-1:0] fill_end_r,  fill_end_nxt;
  logic [7:0]    fill_attr_r, fill_attr_nxt;
  logic          rd_ok_r,     rd_ok_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_char_r,  out_char_nxt;
  logic [7:0]    out_attr_r,  out_attr_nxt;
  logic [6:0]    out_col_r,   out_col_nxt;
  logic [4:0]    out_row_r,   out_row_nxt;

  // input fields
  logic [1:0] in_cmd;
  logic [7:0] in_char;
  logic [4:0] in_rrow;
  logic [6:0] in_rcol;
  logic       accept;

  assign in_cmd  = in_tuser;
  assign in_char = in_tdata[7:0];
  assign in_rrow = in_tdata[12:8];
  assign in_rcol = in_tdata[19:13];

  // cell store ports
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  cell_t         mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  cell_t         mem_rdata;

  // cursor arithmetic for a character write
  logic [CW:0]   col_inc;
  logic [RW:0]   row_inc;
  logic          is_newline;
  logic          col_wrap;
  logic          row_over;
  logic          rd_in_range;
  logic          fill_row_done;
  logic          fill_all_done;
  logic          out_free;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign is_newline  = (in_char == CH_NEWLINE);
  assign col_inc     = {1'b0, cur_col_r} + (CW+1)'(1);
  assign row_inc     = {1'b0, cur_row_r} + (RW+1)'(1);
  assign col_wrap    = is_newline || (col_inc == (CW+1)'(COLUMNS));
  assign row_over    = col_wrap && (row_inc == (RW+1)'(ROWS));
  assign rd_in_range = (32'(in_rrow) < ROWS) && (32'(in_rcol) < COLUMNS);

  assign fill_row_done = (fill_col_r == CW'(COLUMNS - 1));
  assign fill_all_done = fill_row_done && (fill_row_r == fill_end_r);

  // write port: the blanking sweep or a character at the cursor
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {fill_row_r, fill_col_r};
    mem_wdata = make_cell(CH_SPACE, fill_attr_r);
    if (state_r == ST_INIT || state_r == ST_FILL) begin
      mem_we = 1'b1;
    end else if (accept && in_cmd == CMD_WRITE && !is_newline) begin
      mem_we    = 1'b1;
      mem_waddr = {ring_row(top_r, cur_row_r), cur_col_r};
      mem_wdata = make_cell(in_char, attr_r);
    end
  end

  // read port: issued on acceptance, data is ready in the response state
  assign mem_re    = accept && (in_cmd == CMD_READ) && rd_in_range;
  assign mem_raddr = {ring_row(top_r, RW'(in_rrow)), CW'(in_rcol)};

  always_comb begin
    state_nxt     = state_r;
    cur_col_nxt   = cur_col_r;
    cur_row_nxt   = cur_row_r;
    top_nxt       = top_r;
    attr_nxt      = cfg_wr_en ? cfg_wr_data : attr_r;
    fill_col_nxt  = fill_col_r;
    fill_row_nxt  = fill_row_r;
    fill_end_nxt  = fill_end_r;
    fill_attr_nxt = fill_attr_r;
    rd_ok_nxt     = rd_ok_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_char_nxt  = out_char_r;
    out_attr_nxt  = out_attr_r;
    out_col_nxt   = out_col_r;
    out_row_nxt   = out_row_r;

    case (state_r)
      ST_INIT, ST_FILL: begin
        // sweep the cells row by row
        if (fill_row_done) begin
          fill_col_nxt = '0;
          fill_row_nxt = fill_row_r + RW'(1);
        end else begin
          fill_col_nxt = fill_col_r + CW'(1);
        end
        if (fill_all_done) begin
          state_nxt = (state_r == ST_INIT) ? ST_IDLE : ST_RESP;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          rd_ok_nxt = mem_re;
          state_nxt = ST_RESP;
          case (in_cmd)
            CMD_WRITE: begin
              if (row_over) begin
                // scroll: the old top row becomes the new bottom row and is blanked
                cur_col_nxt   = '0;
                cur_row_nxt   = RW'(ROWS - 1);
                top_nxt       = (top_r == RW'(ROWS - 1)) ? '0 : top_r + RW'(1);
                fill_col_nxt  = '0;
                fill_row_nxt  = top_r;
                fill_end_nxt  = top_r;
                fill_attr_nxt = attr_r;
                state_nxt     = ST_FILL;
              end else if (col_wrap) begin
                cur_col_nxt = '0;
                cur_row_nxt = row_inc[RW-1:0];
              end else begin
                cur_col_nxt = col_inc[CW-1:0];
              end
            end
            CMD_CLEAR: begin
              cur_col_nxt   = '0;
              cur_row_nxt   = '0;
              top_nxt       = '0;
              fill_col_nxt  = '0;
              fill_row_nxt  = '0;
              fill_end_nxt  = RW'(ROWS - 1);
              fill_attr_nxt = attr_r;
              state_nxt     = ST_FILL;
            end
            default: begin
            end
          endcase
        end
      end
      ST_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = rd_ok_r ? mem_rdata[7:0]  : 8'd0;
          out_attr_nxt  = rd_ok_r ? mem_rdata[15:8] : 8'd0;
          out_col_nxt   = 7'(cur_col_r);
          out_row_nxt   = 5'(cur_row_r);
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      top_r       <= '0;
      attr_r      <= ATTR_RESET;
      fill_col_r  <= '0;
      fill_row_r  <= '0;
      fill_end_r  <= RW'(ROWS - 1);
      fill_attr_r <= ATTR_RESET;
      rd_ok_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_col_r   <= cur_col_nxt;
      cur_row_r   <= cur_row_nxt;
      top_r       <= top_nxt;
      attr_r      <= attr_nxt;
      fill_col_r  <= fill_col_nxt;
      fill_row_r  <= fill_row_nxt;
      fill_end_r  <= fill_end_nxt;
      fill_attr_r <= fill_attr_nxt;
      rd_ok_r     <= rd_ok_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    out_char_r <= out_char_nxt;
    out_attr_r <= out_attr_nxt;
    out_col_r  <= out_col_nxt;
    out_row_r  <= out_row_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_row_r, out_col_r, out_attr_r, out_char_r};

  // cell store, rows addressed as a ring
  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (DEPTH)
  ) u_cells (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  // cursor stays on screen
  a_cursor_row: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cur_row_r) < ROWS)
    else $error("cursor row beyond last row");

  a_cursor_col: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cur_col_r) < COLUMNS)
    else $error("cursor column beyond last column");

  // ring top pointer stays within the rows
  a_top_row: assert property (@(posedge clk) disable iff (!rst_n)
    32'(top_r) < ROWS)
    else $error("top row pointer out of range");

  // only one transaction in flight
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second transaction taken while one is in flight");

endmodule

`default_nettype wire

// ===== tb/tb_text_console_writer_top.sv =====
// self-checking testbench for the text console writer: directed table, then random text traffic
`timescale 1ns / 1ps

module tb_text_console_writer_top;
  import tcw_pkg::*;

  localparam int COLS = COLUMNS_DEF;
  localparam int ROWS = ROWS_DEF;
  localparam int CELLS = COLS * ROWS;
  // code the block does not define; it must leave the console untouched
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 130;
  localparam int DIRECTED_ROWS = 22;
  // a clear walks the whole store, so let that much time pass before ending
  localparam int SETTLE_CYCLES = CELLS + 16;

  // one result transaction, laid out as out_tdata[27:0]
  typedef struct packed {
    logic [4:0] cursor_row;
    logic [6:0] cursor_col;
    logic [7:0] cell_attr;
    logic [7:0] cell_char;
  } console_result_t;

  // one row of the directed table; the expected fields count only where typed is set
  typedef struct {
    logic [1:0] cmd;
    logic [7:0] ch;
    logic [4:0] rd_row;
    logic [6:0] rd_col;
    bit         typed;
    logic [7:0] exp_char;
    logic [7:0] exp_attr;
    logic [6:0] exp_col;
    logic [4:0] exp_row;
  } directed_row_t;

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata    = '0;   // [7:0] char_code, [12:8] read_row, [19:13] read_col
  logic [1:0]  in_tuser    = '0;   // [1:0] command
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [31:0] out_tdata;          // [7:0] cell_char, [15:8] cell_attr,
                                   // [22:16] cursor_col, [27:23] cursor_row
  logic        cfg_wr_en   = 1'b0;
  logic [7:0]  cfg_wr_data = '0;   // [7:0] text_attribute

  // shadow copy of the console: cell store, cursor and attribute register
  logic [15:0] shadow_cells [CELLS];
  int unsigned shadow_col;
  int unsigned shadow_row;
  logic [7:0]  shadow_attr;

  console_result_t pending_results [$];
  int mismatch_count = 0;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  // characters still to go in the current random text line
  int line_left = 0;

  text_console_writer_top i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit, well above a run made entirely of clears with every stall
  initial begin
    #100_000_000;
    $display("status: fail");
    $finish;
  end

  // applies one accepted transaction to the shadow console and returns its result
  function automatic console_result_t console_step(logic [1:0] cmd, logic [7:0] ch,
                                                   logic [4:0] rd_row, logic [6:0] rd_col);
    console_result_t res;
    res = '0;
    case (cmd)
      CMD_WRITE: begin
        if (ch == CH_NEWLINE) begin
          shadow_col = 0;
          shadow_row++;
        end else begin
          shadow_cells[shadow_row * COLS + shadow_col] = {shadow_attr, ch};
          shadow_col++;
        end
        if (shadow_col >= COLS) begin
          shadow_col = 0;
          shadow_row++;
        end
        // past the bottom row: scroll up and blank the new bottom row
        if (shadow_row >= ROWS) begin
          for (int i = 0; i < CELLS - COLS; i++) shadow_cells[i] = shadow_cells[i + COLS];
          for (int i = CELLS - COLS; i < CELLS; i++) shadow_cells[i] = {shadow_attr, CH_SPACE};
          shadow_row = ROWS - 1;
          shadow_col = 0;
        end
      end
      CMD_CLEAR: begin
        for (int i = 0; i < CELLS; i++) shadow_cells[i] = {shadow_attr, CH_SPACE};
        shadow_col = 0;
        shadow_row = 0;
      end
      CMD_READ: begin
        // reads off the screen give a zero cell
        if (rd_row < ROWS && rd_col < COLS)
          {res.cell_attr, res.cell_char} = shadow_cells[rd_row * COLS + rd_col];
      end
      default: ;
    endcase
    res.cursor_col = 7'(shadow_col);
    res.cursor_row = 5'(shadow_row);
    return res;
  endfunction

  // offers one transaction, holding tvalid until the block takes it
  task automatic send_item(logic [1:0] cmd, logic [7:0] ch, logic [4:0] rd_row,
                           logic [6:0] rd_col, bit typed, console_result_t typed_res);
    console_result_t predicted;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {4'b0, rd_col, rd_row, ch};
    do @(posedge clk); while (!in_tready);
    predicted = console_step(cmd, ch, rd_row, rd_col);
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  // writes the attribute register once every result is home and the block is quiet
  task automatic set_attribute(logic [7:0] value);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    shadow_attr = value;
  endtask

  function automatic void check_field(string field, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      mismatch_count++;
    end
  endfunction

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk) out_tready <= ($urandom_range(99) >= receiver_stall_pct);

  // result side: every accepted transaction is matched against the oldest expectation
  always @(posedge clk) begin
    console_result_t got;
    console_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = console_result_t'(out_tdata[27:0]);
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h", $time, out_tdata);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("cell_char", want.cell_char, got.cell_char);
        check_field("cell_attr", want.cell_attr, got.cell_attr);
        check_field("cursor_col", 8'(want.cursor_col), 8'(got.cursor_col));
        check_field("cursor_row", 8'(want.cursor_row), 8'(got.cursor_row));
      end
    end
  end

  initial begin
    directed_row_t script [DIRECTED_ROWS];
    logic [7:0] attr_plan [PHASES];
    logic [1:0] cmd;
    logic [7:0] ch;
    logic [4:0] rd_row;
    logic [6:0] rd_col;
    int pick;

    for (int i = 0; i < CELLS; i++) shadow_cells[i] = {ATTR_RESET, CH_SPACE};
    shadow_col  = 0;
    shadow_row  = 0;
    shadow_attr = ATTR_RESET;

    script = '{
      // blank screen straight after reset, both corners
      '{CMD_READ,   8'h00, 5'd0,  7'd0,   1'b1, 8'h20, 8'h02, 7'd0, 5'd0},
      '{CMD_READ,   8'hFF, 5'd24, 7'd79,  1'b1, 8'h20, 8'h02, 7'd0, 5'd0},
      // reads off the screen
      '{CMD_READ,   8'h00, 5'd25, 7'd0,   1'b1, 8'h00, 8'h00, 7'd0, 5'd0},
      '{CMD_READ,   8'h00, 5'd0,  7'd80,  1'b1, 8'h00, 8'h00, 7'd0, 5'd0},
      '{CMD_READ,   8'hFF, 5'd31, 7'd127, 1'b1, 8'h00, 8'h00, 7'd0, 5'd0},
      // unused command code changes nothing
      '{CMD_UNUSED, 8'h41, 5'd31, 7'd127, 1'b1, 8'h00, 8'h00, 7'd0, 5'd0},
      // character writes, extreme bytes among them
      '{CMD_WRITE,  8'h41, 5'd31, 7'd127, 1'b0, 8'h00, 8'h00, 7'd0, 5'd0},
      '{CMD_WRITE,  8'h00, 5'd0,  7'd0,   1'b0, 8'h00, 8'h00, 7'd0, 5'd0},
      '{CMD_WRITE,  8'hFF, 5'd0,  7'd0,   1'b0, 8'h00, 8'h00, 7'd0, 5'd0},
      '{CMD_READ,   8'h00, 5'd0,  7'd0,   1'b0, 8'h00, 8'h00, 7'd0, 5'd0},
      '{CMD_READ,   8'h00, 5'd0,  7'd1,   1'b0, 8'h00, 8'h00, 7'd0, 5'd0},
      '{CMD_READ,   8'h00, 5'd0,  7'd2,   1'b0, 8'h00, 8'h00, 7'd0, 5'd0},
      // newline moves down without storing anything
      '{CMD_WRITE,  CH_NEWLINE, 5'd0, 7'd0, 1'b0, 8'h00, 8'h00, 7'd0, 5'd0},
      '{CMD_READ,   8'h00, 5'd0,  7'd3,   1'b0, 8'h00, 8'h00, 7'd0, 5'd0},
      '{CMD_WRITE,  CH_NEWLINE, 5'd0, 7'd0, 1'b0, 8'h00, 8'h00, 7'd0, 5'd0},
      // bytes either side of newline are stored as usual
      '{CMD_WRITE,  8'h0B, 5'd0,  7'd0,   1'b0, 8'h00, 8'h00, 7'd0, 5'd0},
      '{CMD_WRITE,  8'h09, 5'd0,  7'd0,   1'b0, 8'h00, 8'h00, 7'd0, 5'd0},
      '{CMD_READ,   8'h00, 5'd2,  7'd0,   1'b0, 8'h00, 8'h00, 7'd0, 5'd0},
      '{CMD_UNUSED, 8'hFF, 5'd0,  7'd0,   1'b0, 8'h00, 8'h00, 7'd0, 5'd0},
      // clear homes the cursor and blanks the cells
      '{CMD_CLEAR,  8'hFF, 5'd31, 7'd127, 1'b1, 8'h00, 8'h00, 7'd0, 5'd0},
      '{CMD_READ,   8'h00, 5'd2,  7'd0,   1'b1, 8'h20, 8'h02, 7'd0, 5'd0},
      '{CMD_READ,   8'h00, 5'd0,  7'd0,   1'b1, 8'h20, 8'h02, 7'd0, 5'd0}
    };
    attr_plan = '{8'h00, 8'hFF, 8'h5A, 8'h80, 8'h01, 8'hC3, 8'hFE, 8'h00};

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed part, no idling on either side
    foreach (script[i])
      send_item(script[i].cmd, script[i].ch, script[i].rd_row, script[i].rd_col,
                script[i].typed, {script[i].exp_row, script[i].exp_col,
                                  script[i].exp_attr, script[i].exp_char});

    for (int p = 0; p < PHASES; p++) begin
      // new attribute only with the pipeline drained; this is also the sender pause
      set_attribute((p == PHASES - 1) ? 8'($urandom) : attr_plan[p]);
      case (p % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 53; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 53; end
        default: begin sender_idle_pct = 14; receiver_stall_pct = 14; end
      endcase

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        ch     = 8'($urandom);
        rd_row = 5'($urandom);
        rd_col = 7'($urandom);
        pick   = $urandom_range(999);
        if (pick < 3) begin
          cmd = CMD_CLEAR;
        end else if (pick < 25) begin
          cmd = CMD_UNUSED;
        end else if (pick < 275) begin
          cmd  = CMD_READ;
          pick = $urandom_range(9);
          if (pick < 4) begin
            // around the text just written
            rd_row = 5'(shadow_row);
            rd_col = 7'($urandom_range(shadow_col));
          end else if (pick < 9) begin
            rd_row = 5'($urandom_range(ROWS - 1));
            rd_col = 7'($urandom_range(COLS - 1));
          end
          // otherwise the full field range, mostly off the screen
        end else begin
          // text written as lines: mostly short, some long enough to wrap
          cmd = CMD_WRITE;
          if (line_left == 0) begin
            if ($urandom_range(9) != 0) ch = CH_NEWLINE;
            pick = $urandom_range(9);
            if (pick < 5) line_left = $urandom_range(3);
            else if (pick < 8) line_left = $urandom_range(20);
            else line_left = $urandom_range(100);
          end else begin
            line_left--;
          end
        end
        send_item(cmd, ch, rd_row, rd_col, 1'b0, '0);
      end
    end

    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
